FILE: design/tecg_pkg.sv
// Shared types and constants for the tagged ECG lead deframer.
package tecg_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned ValueW = 32;
  localparam int unsigned PartW = 24;
  localparam int unsigned LeftW = 2;
  localparam int unsigned CfgIndexW = 8;

  localparam int EcgSampleBytesDef = 3;
  localparam int LeadSampleBytesDef = 4;

  localparam logic [ByteW-1:0] EscapeByteRst = 8'h10;
  localparam logic [ByteW-1:0] EcgTagRst = 8'h45;
  localparam logic [ByteW-1:0] LeadTagRst = 8'h4C;
  localparam logic [ByteW-1:0] SkipTagRst = 8'h46;

  typedef enum logic [CfgIndexW-1:0] {
    RegEscapeByte = 8'd0,
    RegEcgTag = 8'd1,
    RegLeadTag = 8'd2,
    RegSkipTag = 8'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PhBoundary = 3'd0,
    PhGotDle = 3'd1,
    PhAfterTag = 3'd2,
    PhTagDle = 3'd3,
    PhBody = 3'd4
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] escape_byte;
    logic [ByteW-1:0] ecg_tag;
    logic [ByteW-1:0] lead_tag;
    logic [ByteW-1:0] skip_tag;
  } cfg_t;

  typedef struct packed {
    logic start_new;
    logic [ByteW-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic in_sync;
    logic sample_kind;
    logic [ValueW-1:0] sample_value;
  } result_t;

endpackage

FILE: design/tecg_cfg_regs.sv
// Configuration register file for the escape byte and the three tag bytes.
module tecg_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tecg_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [tecg_pkg::ByteW-1:0]     cfg_data_i,
  output tecg_pkg::cfg_t                cfg_o
);
  import tecg_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegEscapeByte: cfg_d.escape_byte = cfg_data_i;
        RegEcgTag:     cfg_d.ecg_tag = cfg_data_i;
        RegLeadTag:    cfg_d.lead_tag = cfg_data_i;
        RegSkipTag:    cfg_d.skip_tag = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.escape_byte <= EscapeByteRst;
      cfg_q.ecg_tag <= EcgTagRst;
      cfg_q.lead_tag <= LeadTagRst;
      cfg_q.skip_tag <= SkipTagRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: design/tecg_in_reg.sv
// Input register stage holding one accepted byte until the parser takes it.
module tecg_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tecg_pkg::in_item_t in_item_i,
  input  logic               advance_i,
  output logic               item_valid_o,
  output tecg_pkg::in_item_t item_o
);
  import tecg_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  assign in_ready_o = !valid_q || advance_i;
  assign load = in_valid_i && in_ready_o;
  assign item_valid_o = valid_q;
  assign item_o = item_q;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

endmodule

FILE: design/tecg_parser.sv
// Parser state and the combinational step logic that handles one byte.
module tecg_parser #(
  parameter int EcgLen = tecg_pkg::EcgSampleBytesDef,
  parameter int LeadLen = tecg_pkg::LeadSampleBytesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  tecg_pkg::in_item_t item_i,
  input  tecg_pkg::cfg_t     cfg_i,
  output logic               emit_o,
  output tecg_pkg::result_t  result_o
);
  import tecg_pkg::*;

  localparam logic [LeftW-1:0] EcgLeft = LeftW'(EcgLen - 1);
  localparam logic [LeftW-1:0] LeadLeft = LeftW'(LeadLen - 1);

  logic             sync_q, sync_d, sync_c;
  logic             lead_q, lead_d, lead_c;
  phase_e           phase_q, phase_d, phase_c;
  logic [LeftW-1:0] left_q, left_d, left_c, n_left;
  logic [PartW-1:0] part_q, part_d, part_c;
  logic [ByteW-1:0] b;
  logic             begin_s, is_esc;

  assign b = item_i.data_byte;
  assign is_esc = (b == cfg_i.escape_byte);

  // A start_new item sees the cleared state.
  always_comb begin
    sync_c = item_i.start_new ? 1'b0 : sync_q;
    lead_c = item_i.start_new ? 1'b0 : lead_q;
    phase_c = item_i.start_new ? PhBoundary : phase_q;
    left_c = item_i.start_new ? '0 : left_q;
    part_c = item_i.start_new ? '0 : part_q;
  end

  always_comb begin
    sync_d = sync_c;
    lead_d = lead_c;
    phase_d = phase_c;
    left_d = left_c;
    part_d = part_c;
    begin_s = 1'b0;
    emit_o = 1'b0;
    result_o.in_sync = 1'b1;
    result_o.sample_kind = lead_c;
    result_o.sample_value = '0;

    unique case (phase_c) inside
      PhGotDle, PhTagDle: begin
        if (phase_c == PhTagDle && is_esc) begin
          begin_s = 1'b1;
        end else if (phase_c == PhGotDle && sync_c && is_esc) begin
          begin_s = 1'b1;
        end else begin
          // A tag DLE that is not doubled drops sync and reads b as a tag.
          if (phase_c == PhTagDle) begin
            sync_d = 1'b0;
          end
          if (b == cfg_i.ecg_tag) begin
            lead_d = 1'b0;
            phase_d = PhAfterTag;
          end else if (b == cfg_i.lead_tag) begin
            lead_d = 1'b1;
            phase_d = PhAfterTag;
          end else if (b == cfg_i.skip_tag) begin
            phase_d = PhBoundary;
          end else begin
            // Unknown tag: sync drops and b is seen again at a boundary.
            sync_d = 1'b0;
            phase_d = is_esc ? PhGotDle : PhBoundary;
          end
        end
      end
      PhAfterTag: begin
        if (is_esc) begin
          phase_d = PhTagDle;
        end else begin
          begin_s = 1'b1;
        end
      end
      PhBody: begin
        part_d = {part_c[PartW-ByteW-1:0], b};
        left_d = left_c - LeftW'(1);
        if (left_c == LeftW'(1)) begin
          emit_o = 1'b1;
          result_o.sample_value = {part_c, b};
          sync_d = 1'b1;
          phase_d = PhBoundary;
          left_d = '0;
        end
      end
      default: begin
        phase_d = PhBoundary;
        if (is_esc) begin
          phase_d = PhGotDle;
        end else if (sync_c) begin
          begin_s = 1'b1;
        end
      end
    endcase

    n_left = lead_d ? LeadLeft : EcgLeft;
    if (begin_s) begin
      part_d = {{(PartW-ByteW){1'b0}}, b};
      left_d = n_left;
      if (n_left == '0) begin
        emit_o = 1'b1;
        result_o.sample_value = {{(ValueW-ByteW){1'b0}}, b};
        sync_d = 1'b1;
        phase_d = PhBoundary;
      end else begin
        phase_d = PhBody;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= 1'b0;
      lead_q <= 1'b0;
      phase_q <= PhBoundary;
      left_q <= '0;
      part_q <= '0;
    end else if (step_i) begin
      sync_q <= sync_d;
      lead_q <= lead_d;
      phase_q <= phase_d;
      left_q <= left_d;
      part_q <= part_d;
    end
  end

endmodule

FILE: design/tecg_out_reg.sv
// Result register that holds one finished sample until the sink takes it.
module tecg_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  tecg_pkg::result_t result_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tecg_pkg::result_t result_o
);
  import tecg_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  assign free_o = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign result_o = result_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

endmodule

FILE: design/tagged_ecg_lead_deframer.sv
// Top level of the tagged ECG / lead-detect byte stream deframer.
// The block parses a sensor FIFO byte stream in which an escape (DLE) byte
// followed by a tag byte selects the kind of the samples that follow: the
// ECG tag starts ECG samples and the lead tag starts lead-detect samples,
// while a DLE pair with the skip tag is ignored. Once in sync, samples of the
// current kind follow back to back without a header, and a doubled DLE at a
// sample's first byte stands for one literal DLE byte. Each finished sample
// leaves as one item with its first byte in the most significant position.
// The block takes one byte per clock cycle while the stream is not stalled:
// an accepted byte is registered in the input register, the parser handles
// it combinationally against its state registers, and a finished sample is
// then registered in the result register for the sink. A finished
// sample that waits for the sink holds up the parser: while the result
// register is full and not being drained, the input register takes at most
// one more byte and then the stream stalls, even for bytes that would yield
// no sample. Setting start_new on a byte clears the parser state before that
// byte is handled; tlast on the input marks the end of one FIFO read and
// does not change the parse. Configuration writes are taken in every cycle
// and should be made only while the block is idle.
module tagged_ecg_lead_deframer #(
  parameter int ECG_SAMPLE_BYTES = tecg_pkg::EcgSampleBytesDef,
  parameter int LEAD_SAMPLE_BYTES = tecg_pkg::LeadSampleBytesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input bytes.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] data_byte
  input  logic [0:0]                     s_axis_tuser,  // [0] start_new
  input  logic                           s_axis_tlast,  // read_end
  // Finished samples.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [31:0]                    m_axis_tdata,  // [31:0] sample_value
  output logic [1:0]                     m_axis_tuser,  // [0] sample_kind, [1] in_sync
  // Configuration writes.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tecg_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [tecg_pkg::ByteW-1:0]     cfg_data_i
);
  import tecg_pkg::*;

  // Sample lengths are clamped into one to four bytes.
  localparam int EcgLen = (ECG_SAMPLE_BYTES < 1) ? 1 :
                          (ECG_SAMPLE_BYTES > 4) ? 4 : ECG_SAMPLE_BYTES;
  localparam int LeadLen = (LEAD_SAMPLE_BYTES < 1) ? 1 :
                           (LEAD_SAMPLE_BYTES > 4) ? 4 : LEAD_SAMPLE_BYTES;

  cfg_t     cfg;
  in_item_t in_item, item;
  result_t  step_result, out_result;
  logic     item_valid, advance, emit, out_free;
  logic     read_end_seen;

  assign in_item.data_byte = s_axis_tdata;
  assign in_item.start_new = s_axis_tuser[0];
  // The end of a FIFO read carries no meaning for the parse: the stream is
  // treated as continuous across reads.
  assign read_end_seen = s_axis_tlast;

  // An item moves from the input register through the parser whenever the
  // result register can take whatever it produces.
  assign advance = item_valid && out_free;

  tecg_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tecg_in_reg u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid || (read_end_seen && 1'b0)),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  tecg_parser #(
    .EcgLen  (EcgLen),
    .LeadLen (LeadLen)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (item),
    .cfg_i    (cfg),
    .emit_o   (emit),
    .result_o (step_result)
  );

  tecg_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && emit),
    .result_i    (step_result),
    .free_o      (out_free),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (out_result)
  );

  assign m_axis_tdata = out_result.sample_value;
  assign m_axis_tuser = {out_result.in_sync, out_result.sample_kind};

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the tagged ECG lead deframer.
module testbench;
  import tecg_pkg::*;

  // Sample lengths as the block clamps its parameters.
  localparam int EcgLen = (EcgSampleBytesDef < 1) ? 1 :
                          (EcgSampleBytesDef > 4) ? 4 : EcgSampleBytesDef;
  localparam int LeadLen = (LeadSampleBytesDef < 1) ? 1 :
                           (LeadSampleBytesDef > 4) ? 4 : LeadSampleBytesDef;
  localparam int StallLimit = 5000;
  localparam int HoldCycles = 300;
  localparam int SettleCycles = 8;
  localparam logic [CfgIndexW-1:0] BadRegIndex = 8'hFF;

  typedef struct {
    logic [ByteW-1:0] data;
    logic             start_new;
    logic             read_end;
  } fifo_byte_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata = '0;
  logic [0:0]        s_axis_tuser = '0;
  logic              s_axis_tlast = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [31:0]       m_axis_tdata;
  logic [1:0]        m_axis_tuser;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i = '0;
  logic [ByteW-1:0]  cfg_data_i = '0;

  // Idle rates in percent, a pending hold-off request for the sink, error count.
  int src_idle_pct = 24;
  int sink_idle_pct = 70;
  int hold_request = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int mismatch_count = 0;
  int stim_count = 0;

  // Parser mirror: register copy and state, updated on every accepted item.
  cfg_t        dl_cfg;
  logic        dl_synced;
  logic        dl_lead;
  phase_e      dl_phase;
  logic [2:0]  dl_left;
  logic [31:0] dl_part;
  result_t     expected_samples[$];

  // Register values the stimulus is built for, and the bytes still to send.
  cfg_t        gen_cfg;
  fifo_byte_t  byte_queue[$];

  tagged_ecg_lead_deframer u_top (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic clear_parse();
    dl_synced = 1'b0;
    dl_lead = 1'b0;
    dl_phase = PhBoundary;
    dl_left = '0;
    dl_part = '0;
  endtask

  task automatic emit_sample();
    result_t r;
    dl_synced = 1'b1;
    dl_phase = PhBoundary;
    dl_left = '0;
    r.in_sync = 1'b1;
    r.sample_kind = dl_lead;
    r.sample_value = dl_part;
    expected_samples.push_back(r);
  endtask

  task automatic open_sample(input logic [7:0] b);
    dl_part = {24'b0, b};
    dl_left = dl_lead ? 3'(LeadLen - 1) : 3'(EcgLen - 1);
    if (dl_left == 0) emit_sample();
    else dl_phase = PhBody;
  endtask

  // One byte through the parser. A byte that breaks a header is handled
  // again in the phase it falls back to, hence the bounded loop.
  task automatic deframe_byte(input logic [7:0] b, input logic restart);
    bit done;
    int pass;
    done = 1'b0;
    if (restart) clear_parse();
    for (pass = 0; pass < 4 && !done; pass++) begin
      case (dl_phase)
        PhGotDle: begin
          done = 1'b1;
          if (b == dl_cfg.escape_byte && dl_synced) open_sample(b);
          else if (b == dl_cfg.ecg_tag) begin
            dl_lead = 1'b0;
            dl_phase = PhAfterTag;
          end else if (b == dl_cfg.lead_tag) begin
            dl_lead = 1'b1;
            dl_phase = PhAfterTag;
          end else if (b == dl_cfg.skip_tag) dl_phase = PhBoundary;
          else begin
            dl_synced = 1'b0;
            dl_phase = PhBoundary;
            done = 1'b0;
          end
        end
        PhAfterTag: begin
          done = 1'b1;
          if (b == dl_cfg.escape_byte) dl_phase = PhTagDle;
          else open_sample(b);
        end
        PhTagDle: begin
          if (b == dl_cfg.escape_byte) begin
            open_sample(b);
            done = 1'b1;
          end else begin
            dl_synced = 1'b0;
            dl_phase = PhGotDle;
          end
        end
        PhBody: begin
          done = 1'b1;
          dl_part = {dl_part[23:0], b};
          if (dl_left != 0) dl_left--;
          if (dl_left == 0) emit_sample();
        end
        default: begin
          done = 1'b1;
          dl_phase = PhBoundary;
          if (b == dl_cfg.escape_byte) dl_phase = PhGotDle;
          else if (dl_synced) open_sample(b);
        end
      endcase
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input logic restart);
    fifo_byte_t it;
    it.data = b;
    it.start_new = restart;
    it.read_end = ($urandom_range(0, 7) == 0);
    byte_queue.push_back(it);
    stim_count++;
  endtask

  // Random byte that hits the escape value often enough to matter.
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 5) == 0) return gen_cfg.escape_byte;
    return 8'($urandom);
  endfunction

  // A sample body; a first byte equal to the escape byte is doubled.
  task automatic push_sample(input int len);
    logic [7:0] b;
    int k;
    b = pick_byte();
    push_byte(b, 1'b0);
    if (b == gen_cfg.escape_byte) push_byte(b, 1'b0);
    for (k = 1; k < len; k++) push_byte(pick_byte(), 1'b0);
  endtask

  task automatic push_directed();
    logic [7:0] esc;
    esc = gen_cfg.escape_byte;
    // ECG header, a sample with a raw escape byte in its body.
    push_byte(esc, 1'b0);
    push_byte(gen_cfg.ecg_tag, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(esc, 1'b0);
    // Doubled escape while in sync is a literal first byte.
    push_byte(esc, 1'b0);
    push_byte(esc, 1'b0);
    push_byte(8'hA5, 1'b0);
    push_byte(8'h5A, 1'b0);
    // Skip pair keeps sync, an unknown byte after the escape drops it.
    push_byte(esc, 1'b0);
    push_byte(gen_cfg.skip_tag, 1'b0);
    push_byte(esc, 1'b0);
    push_byte(8'h33, 1'b0);
    // Lead tag, escape, then a non-escape byte that is taken as a tag.
    push_byte(esc, 1'b0);
    push_byte(gen_cfg.lead_tag, 1'b0);
    push_byte(esc, 1'b0);
    push_byte(gen_cfg.lead_tag, 1'b0);
    push_byte(esc, 1'b0);
    push_byte(esc, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    // Restart clears sync, so this data byte is dropped.
    push_byte(8'h12, 1'b1);
    // Doubled escape without sync: the second one opens a new header.
    push_byte(esc, 1'b0);
    push_byte(esc, 1'b0);
    push_byte(gen_cfg.ecg_tag, 1'b0);
    push_byte(8'h11, 1'b0);
    push_byte(8'h22, 1'b0);
    push_byte(8'h33, 1'b0);
  endtask

  // Mostly well-formed runs of samples, with loose samples, noise and
  // broken headers mixed in.
  task automatic push_random(input int count);
    int stop;
    int sel;
    int runs;
    int len;
    logic lead;
    stop = stim_count + count;
    while (stim_count < stop) begin
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        lead = 1'($urandom_range(0, 1));
        len = lead ? LeadLen : EcgLen;
        push_byte(gen_cfg.escape_byte, $urandom_range(0, 15) == 0);
        push_byte(lead ? gen_cfg.lead_tag : gen_cfg.ecg_tag, 1'b0);
        runs = $urandom_range(1, 6);
        repeat (runs) begin
          if ($urandom_range(0, 9) == 0) begin
            push_byte(gen_cfg.escape_byte, 1'b0);
            push_byte(gen_cfg.skip_tag, 1'b0);
          end
          push_sample(len);
        end
      end else if (sel < 72) begin
        push_sample($urandom_range(0, 1) ? LeadLen : EcgLen);
      end else if (sel < 88) begin
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom), $urandom_range(0, 9) == 0);
      end else begin
        push_byte(gen_cfg.escape_byte, 1'b0);
        if ($urandom_range(0, 1) == 1) begin
          push_byte($urandom_range(0, 1) ? gen_cfg.lead_tag : gen_cfg.ecg_tag, 1'b0);
          push_byte(gen_cfg.escape_byte, 1'b0);
        end
        push_byte(pick_byte(), 1'b0);
      end
    end
  endtask

  // Returns once every byte is taken, every sample has come out and the
  // pipeline has had time to finish any byte that yields no sample.
  task automatic wait_drained();
    while (byte_queue.size() != 0 || s_axis_tvalid || expected_samples.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes all four registers and one write to an index past the last one.
  task automatic program_cfg(input cfg_t c);
    logic [CfgIndexW-1:0] idx [5];
    logic [ByteW-1:0] val [5];
    int i;
    idx[0] = RegEscapeByte;
    val[0] = c.escape_byte;
    idx[1] = RegEcgTag;
    val[1] = c.ecg_tag;
    idx[2] = RegLeadTag;
    val[2] = c.lead_tag;
    idx[3] = RegSkipTag;
    val[3] = c.skip_tag;
    idx[4] = BadRegIndex;
    val[4] = ~c.escape_byte;
    gen_cfg = c;
    for (i = 0; i < 5; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i <= val[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Byte driver.
  always @(posedge clk_i) begin
    fifo_byte_t it;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (byte_queue.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        it = byte_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= it.data;
        s_axis_tuser <= it.start_new;
        s_axis_tlast <= it.read_end;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Sample sink, with a long hold-off whenever one is requested.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (hold_request != hold_seen) begin
        hold_seen = hold_request;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  // Monitor: tracks register writes and accepted bytes, checks samples,
  // and stops the run when nothing moves for too long.
  always @(posedge clk_i) begin
    result_t want;
    logic active;
    if (rst_ni) begin
      active = 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        active = 1'b1;
        case (cfg_reg_e'(cfg_index_i))
          RegEscapeByte: dl_cfg.escape_byte = cfg_data_i;
          RegEcgTag:     dl_cfg.ecg_tag = cfg_data_i;
          RegLeadTag:    dl_cfg.lead_tag = cfg_data_i;
          RegSkipTag:    dl_cfg.skip_tag = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        active = 1'b1;
        deframe_byte(s_axis_tdata, s_axis_tuser[0]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        active = 1'b1;
        if (expected_samples.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected sample, expected none, actual value %h kind %0d sync %0d",
                   $time, m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]);
        end else begin
          want = expected_samples.pop_front();
          if (m_axis_tdata !== want.sample_value) begin
            mismatch_count++;
            $display("%0t: sample_value mismatch, expected %h, actual %h",
                     $time, want.sample_value, m_axis_tdata);
          end
          if (m_axis_tuser[0] !== want.sample_kind) begin
            mismatch_count++;
            $display("%0t: sample_kind mismatch, expected %0d, actual %0d",
                     $time, want.sample_kind, m_axis_tuser[0]);
          end
          if (m_axis_tuser[1] !== want.in_sync) begin
            mismatch_count++;
            $display("%0t: in_sync mismatch, expected %0d, actual %0d",
                     $time, want.in_sync, m_axis_tuser[1]);
          end
        end
      end
      idle_cycles = active ? 0 : idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    dl_cfg = '{EscapeByteRst, EcgTagRst, LeadTagRst, SkipTagRst};
    gen_cfg = dl_cfg;
    clear_parse();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset register values.
    push_directed();
    push_random(160);
    wait_drained();

    // Extreme values; the sink holds off at the start so the block backs up.
    program_cfg('{8'hFF, 8'h00, 8'h80, 8'h7F});
    hold_request++;
    push_random(160);
    wait_drained();

    // Escape equal to the ECG tag, lead tag equal to the skip tag.
    src_idle_pct = 70;
    sink_idle_pct = 24;
    program_cfg('{8'h00, 8'h00, 8'hFF, 8'hFF});
    push_random(80);
    wait_drained();
    push_random(80);
    wait_drained();

    program_cfg(cfg_t'($urandom));
    push_random(160);
    wait_drained();

    // Back to the reset values, both sides at full rate.
    src_idle_pct = 0;
    sink_idle_pct = 0;
    program_cfg('{EscapeByteRst, EcgTagRst, LeadTagRst, SkipTagRst});
    push_random(160);
    wait_drained();

    if (mismatch_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: sim.f
design/tecg_pkg.sv
design/tecg_cfg_regs.sv
design/tecg_in_reg.sv
design/tecg_parser.sv
design/tecg_out_reg.sv
design/tagged_ecg_lead_deframer.sv
bench/testbench.sv
